// ===== rtl/core/mcoa_pkg.sv =====
package mcoa_pkg;

    // Field widths
    localparam int SampleBits = 12;
    localparam int OffsetBits = 12;
    localparam int DirBits    = 2;
    localparam int PosBits    = 32;
    localparam int VelBits    = 16;
    localparam int IdxBits    = 5;
    localparam int AvgBits    = 16;
    localparam int VelOutBits = 22;

    // Moving average ring
    localparam int AvgTaps  = 8;
    localparam int AvgShift = 3;
    localparam int PtrBits  = 3;
    localparam int SumBits  = AvgBits + AvgShift;

    localparam logic [OffsetBits-1:0] OffsetReset = 12'd2048;

    // Register index of zero_current_offset (paddr[2])
    localparam logic RegOffsetIdx = 1'b0;

    // Current scaling 100000/14978, truncated toward zero. The rounded-up
    // reciprocal with a 26-bit shift is exact for magnitudes below 4096.
    localparam longint ScaleNum     = 100000;
    localparam longint ScaleDen     = 14978;
    localparam int     ScaleShift   = 26;
    localparam int     ScaleMulBits = 29;
    localparam logic [ScaleMulBits-1:0] ScaleMul =
        ScaleMulBits'((((64'd1 << ScaleShift) * ScaleNum) + ScaleDen - 1) / ScaleDen);

    localparam int VelGain = 30;

    // Direction codes
    localparam logic [DirBits-1:0] DirFwd  = 2'b01;
    localparam logic [DirBits-1:0] DirStop = 2'b00;
    localparam logic [DirBits-1:0] DirRev  = 2'b11;

    typedef enum logic [1:0] {
        ST_MEAS     = 2'd0,
        ST_CAPTURE  = 2'd1,
        ST_CAL_END  = 2'd2
    } t_status;

    typedef struct packed {
        logic [SampleBits-1:0]        sample;
        logic                         start;
        logic signed [AvgBits-1:0]    scaled;
        logic [DirBits-1:0]           dir;
        logic [PosBits-1:0]           pos;
        logic signed [VelOutBits-1:0] vel;
    } t_scaled_item;

    typedef struct packed {
        t_status                      status;
        logic [IdxBits-1:0]           idx;
        logic [SampleBits-1:0]        smp;
        logic signed [AvgBits-1:0]    avg;
        logic [DirBits-1:0]           dir;
        logic [PosBits-1:0]           pos;
        logic signed [VelOutBits-1:0] vel;
    } t_result;

endpackage

// ===== rtl/core/motor_current_offset_average_unit.sv =====
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid/tready/tdata[63:0]/tuser  one converter sample with encoder data
// m_axis    out  tvalid/tready/tdata[95:0]/tuser  one result per sample
// apb       in   psel/penable/pwrite/paddr/...    zero_current_offset at byte address 0
//
// Two register stages: scaling (one 12x29 multiply) then ring/sum update or calibration
// capture into the result register; one sample accepted per cycle while m_axis is not stalled.
// The 8-entry ring keeps a running sum, so each update is one add and subtract.
// Active-low sync reset clears ring, sum, calibration state and avg/dir/pos/vel outputs.
// A stalled m_axis holds the result register and back-pressures s_axis through both stages.
module motor_current_offset_average_unit import mcoa_pkg::*; #(
    parameter int CalSamples = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] adc_sample, [13:12] encoder_direction, [45:14] encoder_position,
    // [61:46] encoder_velocity, [63:62] zero
    input  logic [63:0] s_axis_tdata,
    // [0] start_calibration
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] capture_index, [16:5] capture_sample, [32:17] current_average,
    // [34:33] direction_out, [66:35] position_out, [88:67] velocity_out, [95:89] zero
    output logic [95:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [OffsetBits-1:0] r_offset;
    logic                  s1_valid;
    logic                  s1_adv;
    t_scaled_item          s1_item;
    t_result               res;

    // Configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegOffsetIdx) ? 32'(r_offset) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OffsetReset;
        end else if (psel && penable && pwrite && pready && (paddr[2] == RegOffsetIdx)) begin
            r_offset <= pwdata[OffsetBits-1:0];
        end
    end

    mcoa_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_sample (s_axis_tdata[11:0]),
        .i_start  (s_axis_tuser),
        .i_dir    (s_axis_tdata[13:12]),
        .i_pos    (s_axis_tdata[45:14]),
        .i_vel    (s_axis_tdata[61:46]),
        .i_offset (r_offset),
        .i_adv    (s1_adv),
        .o_ready  (s_axis_tready),
        .o_valid  (s1_valid),
        .o_item   (s1_item)
    );

    mcoa_avg #(
        .CalSamples (CalSamples)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .i_item   (s1_item),
        .i_ready  (m_axis_tready),
        .o_adv    (s1_adv),
        .o_valid  (m_axis_tvalid),
        .o_result (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'd0, res.vel, res.pos, res.dir, res.avg, res.smp, res.idx};

    // Assertions

    a_end_no_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_CAL_END) |-> (m_axis_tdata[16:0] == '0))
        else $error("calibration end result carries capture data");

    a_stop_no_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_MEAS) && (m_axis_tdata[34:33] == DirStop)
        |-> (m_axis_tdata[88:67] == '0))
        else $error("velocity nonzero with stopped direction");

    a_offset_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == RegOffsetIdx)
        |=> (r_offset == $past(pwdata[OffsetBits-1:0])))
        else $error("offset register not written");

endmodule

// ===== rtl/core/mcoa_scale.sv =====
module mcoa_scale import mcoa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [SampleBits-1:0] i_sample,
    input  logic                  i_start,
    input  logic [DirBits-1:0]    i_dir,
    input  logic [PosBits-1:0]    i_pos,
    input  logic [VelBits-1:0]    i_vel,
    input  logic [OffsetBits-1:0] i_offset,
    input  logic                  i_adv,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_scaled_item          o_item
);

    localparam int ProdBits = SampleBits + ScaleMulBits;

    logic                         r_valid;
    t_scaled_item                 r_item;
    t_scaled_item                 n_item;

    logic signed [SampleBits:0]   diff;
    logic [SampleBits-1:0]        mag;
    logic [ProdBits-1:0]          prod;
    logic [AvgBits-2:0]           quo;
    logic [VelOutBits-2:0]        vel_mag;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        diff    = $signed({1'b0, i_sample}) - $signed({1'b0, i_offset});
        mag     = diff[SampleBits] ? SampleBits'(-diff) : diff[SampleBits-1:0];
        prod    = ProdBits'(mag) * ProdBits'(ScaleMul);
        quo     = prod[ScaleShift +: AvgBits-1];
        vel_mag = (VelOutBits-1)'(i_vel) * (VelOutBits-1)'(VelGain);

        n_item.sample = i_sample;
        n_item.start  = i_start;
        n_item.pos    = i_pos;
        n_item.scaled = diff[SampleBits] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

        // out-of-range code -2 counts as reverse
        case (i_dir)
            DirFwd: begin
                n_item.dir = DirFwd;
                n_item.vel = $signed({1'b0, vel_mag});
            end
            DirStop: begin
                n_item.dir = DirStop;
                n_item.vel = '0;
            end
            default: begin
                n_item.dir = DirRev;
                n_item.vel = -$signed({1'b0, vel_mag});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/core/mcoa_avg.sv =====
module mcoa_avg import mcoa_pkg::*; #(
    parameter int CalSamples = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_scaled_item i_item,
    input  logic         i_ready,
    output logic         o_adv,
    output logic         o_valid,
    output t_result      o_result
);

    localparam int CntBits = $clog2(CalSamples + 1);
    localparam int IdxWide = (CntBits > IdxBits) ? CntBits : IdxBits;

    logic                         r_valid;
    logic                         r_cal;
    logic [CntBits-1:0]           r_cnt;
    logic signed [AvgBits-1:0]    r_ring [AvgTaps];
    logic [PtrBits-1:0]           r_ptr;
    logic signed [SumBits-1:0]    r_sum;
    t_status                      r_status;
    logic [IdxBits-1:0]           r_idx;
    logic [SampleBits-1:0]        r_smp;
    logic signed [AvgBits-1:0]    r_avg;
    logic [DirBits-1:0]           r_dir;
    logic [PosBits-1:0]           r_pos;
    logic signed [VelOutBits-1:0] r_vel;

    logic                         take;
    logic                         cal_now;
    logic [CntBits-1:0]           cnt_now;
    logic                         capture;
    logic [IdxWide-1:0]           idx_wide;
    logic signed [SumBits-1:0]    n_sum;
    logic [PtrBits-1:0]           n_ptr;

    assign o_adv   = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign take    = i_valid && o_adv;

    assign o_result.status = r_status;
    assign o_result.idx    = r_idx;
    assign o_result.smp    = r_smp;
    assign o_result.avg    = r_avg;
    assign o_result.dir    = r_dir;
    assign o_result.pos    = r_pos;
    assign o_result.vel    = r_vel;

    always_comb begin
        // start flag restarts capture before this sample is handled
        cal_now  = r_cal || i_item.start;
        cnt_now  = i_item.start ? '0 : r_cnt;
        capture  = cal_now && (cnt_now < CntBits'(CalSamples));
        idx_wide = IdxWide'(cnt_now);
        // running sum: drop the oldest entry, add the new one
        n_sum    = r_sum - SumBits'(r_ring[r_ptr]) + SumBits'(i_item.scaled);
        n_ptr    = (r_ptr == PtrBits'(AvgTaps - 1)) ? '0 : r_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cal   <= 1'b0;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_sum   <= '0;
            r_avg   <= '0;
            r_dir   <= '0;
            r_pos   <= '0;
            r_vel   <= '0;
            for (int i = 0; i < AvgTaps; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (o_adv) begin
                r_valid <= i_valid;
            end
            if (take) begin
                if (cal_now) begin
                    if (capture) begin
                        r_cal <= 1'b1;
                        r_cnt <= cnt_now + 1'b1;
                    end else begin
                        r_cal <= 1'b0;
                        r_cnt <= cnt_now;
                    end
                end else begin
                    r_ring[r_ptr] <= i_item.scaled;
                    r_ptr         <= n_ptr;
                    r_sum         <= n_sum;
                    r_avg         <= AvgBits'(n_sum >>> AvgShift);
                    r_dir         <= i_item.dir;
                    r_pos         <= i_item.pos;
                    r_vel         <= i_item.vel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (!cal_now) begin
                r_status <= ST_MEAS;
                r_idx    <= '0;
                r_smp    <= '0;
            end else if (capture) begin
                r_status <= ST_CAPTURE;
                r_idx    <= idx_wide[IdxBits-1:0];
                r_smp    <= i_item.sample;
            end else begin
                r_status <= ST_CAL_END;
                r_idx    <= '0;
                r_smp    <= '0;
            end
        end
    end

endmodule
